@@ hdl/i2cms_pkg.sv @@
// Package for the I2C master bit sequencer: item types, command codes, state encoding.
`timescale 1ns / 1ps

package i2cms_pkg;

	// Command codes carried in the kind field of an input item
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_STOP  = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;
	localparam logic [2:0] KIND_SACK  = 3'd5;
	localparam logic [2:0] KIND_RACK  = 3'd6;

	// Bus operation in progress
	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4,
		OP_SACK  = 3'd5,
		OP_RACK  = 3'd6
	} op_t;

	// Waveform phase within an operation (write byte uses all three)
	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;

	// Bits per byte on the bus
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Reset value of the delay scale register
	localparam logic [7:0] DELAY_SCALE_RST = 8'd1;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] write_data;
		logic       ack_value;
		logic       sda_sample;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_seen;
		logic       rejected;
	} out_item_t;

	// Map a kind code to the operation it starts; tick and the unused code start none
	function automatic op_t kind_to_op(input logic [2:0] kind);
		op_t op;
		unique case (kind)
			KIND_START: op = OP_START;
			KIND_STOP:  op = OP_STOP;
			KIND_WRITE: op = OP_WRITE;
			KIND_READ:  op = OP_READ;
			KIND_SACK:  op = OP_SACK;
			KIND_RACK:  op = OP_RACK;
			default:    op = OP_IDLE;
		endcase
		return op;
	endfunction

endpackage

@@ hdl/i2cms_seq.sv @@
// Pin sequencer state and its one-item step: command start, tick countdown, waveform advance.
`timescale 1ns / 1ps

module i2cms_seq import i2cms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  in_item_t  item,
	input  logic [7:0] delay_scale,
	output out_item_t result
);

	op_t        op_q, op_n;
	logic [1:0] phase_q, phase_n;
	logic [9:0] wait_q, wait_n;
	logic [3:0] bit_cnt_q, bit_cnt_n;
	logic [7:0] shift_q, shift_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       drive_q, drive_n;
	logic       ack_q, ack_n;
	logic [7:0] last_rd_q, last_rd_n;

	op_t        cmd_op;
	logic [7:0] scale_eff;
	logic [9:0] wait_1us, wait_2us, wait_4us;
	logic [3:0] bit_cnt_inc;
	logic [7:0] shift_rd;
	logic       done, rej;

	// Wait lengths: zero scale counts as one
	assign scale_eff   = (delay_scale == 8'd0) ? 8'd1 : delay_scale;
	assign wait_1us    = {2'b00, scale_eff};
	assign wait_2us    = {1'b0, scale_eff, 1'b0};
	assign wait_4us    = {scale_eff, 2'b00};
	assign cmd_op      = kind_to_op(item.kind);
	assign bit_cnt_inc = bit_cnt_q + 4'd1;
	assign shift_rd    = {shift_q[6:0], item.sda_sample};

	// Next state for one item
	always_comb begin
		op_n      = op_q;
		phase_n   = phase_q;
		wait_n    = wait_q;
		bit_cnt_n = bit_cnt_q;
		shift_n   = shift_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		drive_n   = drive_q;
		ack_n     = ack_q;
		last_rd_n = last_rd_q;
		done      = 1'b0;
		rej       = 1'b0;
		if (cmd_op != OP_IDLE) begin
			if (op_q != OP_IDLE) begin
				rej = 1'b1;
			end else begin
				// first pin levels of the new command
				op_n      = cmd_op;
				phase_n   = PH_0;
				bit_cnt_n = 4'd0;
				unique case (cmd_op)
					OP_START: begin
						drive_n = 1'b1; sda_n = 1'b1; scl_n = 1'b1; wait_n = wait_4us;
					end
					OP_STOP: begin
						drive_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0; wait_n = wait_4us;
					end
					OP_WRITE: begin
						drive_n = 1'b1; shift_n = item.write_data;
						sda_n = item.write_data[7]; wait_n = wait_2us;
					end
					OP_READ: begin
						drive_n = 1'b0; shift_n = 8'd0; scl_n = 1'b1; wait_n = wait_2us;
					end
					OP_SACK: begin
						drive_n = 1'b1; sda_n = item.ack_value; wait_n = wait_2us;
					end
					default: begin
						drive_n = 1'b0; sda_n = 1'b1; wait_n = wait_1us;
					end
				endcase
			end
		end else if (op_q != OP_IDLE) begin
			if (wait_q > 10'd1) begin
				wait_n = wait_q - 10'd1;
			end else begin
				// wait expired: next pin changes on this tick
				unique case (op_q)
					OP_START: begin
						if (phase_q == PH_0) begin
							sda_n = 1'b0; phase_n = PH_1; wait_n = wait_4us;
						end else begin
							scl_n = 1'b0; done = 1'b1;
						end
					end
					OP_STOP: begin
						if (phase_q == PH_0) begin
							scl_n = 1'b1; sda_n = 1'b1; phase_n = PH_1; wait_n = wait_4us;
						end else begin
							done = 1'b1;
						end
					end
					OP_WRITE: begin
						if (phase_q == PH_0) begin
							scl_n = 1'b1; phase_n = PH_1; wait_n = wait_2us;
						end else if (phase_q == PH_1) begin
							scl_n = 1'b0; phase_n = PH_2; wait_n = wait_2us;
						end else begin
							bit_cnt_n = bit_cnt_inc;
							shift_n   = {shift_q[6:0], 1'b0};
							if (bit_cnt_inc >= BITS_PER_BYTE) begin
								done = 1'b1;
							end else begin
								sda_n = shift_q[6]; phase_n = PH_0; wait_n = wait_2us;
							end
						end
					end
					OP_READ: begin
						if (phase_q == PH_0) begin
							shift_n = shift_rd; scl_n = 1'b0; phase_n = PH_1; wait_n = wait_2us;
						end else begin
							bit_cnt_n = bit_cnt_inc;
							if (bit_cnt_inc >= BITS_PER_BYTE) begin
								last_rd_n = shift_q; done = 1'b1;
							end else begin
								scl_n = 1'b1; phase_n = PH_0; wait_n = wait_2us;
							end
						end
					end
					OP_SACK: begin
						if (phase_q == PH_0) begin
							scl_n = 1'b1; phase_n = PH_1; wait_n = wait_2us;
						end else begin
							scl_n = 1'b0; done = 1'b1;
						end
					end
					OP_RACK: begin
						if (phase_q == PH_0) begin
							scl_n = 1'b1; phase_n = PH_1; wait_n = wait_1us;
						end else begin
							ack_n = item.sda_sample; scl_n = 1'b0; done = 1'b1;
						end
					end
					default: done = 1'b1;
				endcase
				if (done) begin
					op_n    = OP_IDLE;
					phase_n = PH_0;
					wait_n  = 10'd0;
				end
			end
		end
	end

	// Result reflects the state after this item
	always_comb begin
		result.scl_level = scl_n;
		result.sda_level = sda_n;
		result.sda_drive = drive_n;
		result.busy_res  = (op_n != OP_IDLE);
		result.done_res  = done;
		result.read_data = last_rd_n;
		result.ack_seen  = ack_n;
		result.rejected  = rej;
	end

	// Sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_IDLE;
			phase_q   <= PH_0;
			wait_q    <= 10'd0;
			bit_cnt_q <= 4'd0;
			shift_q   <= 8'd0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			drive_q   <= 1'b1;
			ack_q     <= 1'b0;
			last_rd_q <= 8'd0;
		end else if (step_en) begin
			op_q      <= op_n;
			phase_q   <= phase_n;
			wait_q    <= wait_n;
			bit_cnt_q <= bit_cnt_n;
			shift_q   <= shift_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			drive_q   <= drive_n;
			ack_q     <= ack_n;
			last_rd_q <= last_rd_n;
		end
	end

endmodule

@@ hdl/i2c_master_bit_sequencer_core.sv @@
// Top level of the I2C master bit sequencer: input register, sequencer, two-entry result queue.
`timescale 1ns / 1ps

// I2C master pin sequencer. Each input item is either a tick (one time unit) or a
// command (start, stop, write byte, read byte, send ack, receive ack); each item
// yields exactly one result item with the SCL/SDA pin levels, SDA drive, busy,
// done pulse, last read byte, last ack bit and a rejected flag for a command sent
// while busy. Waits last n us times delay_scale ticks (cfg_wr_data, reset 1, zero
// acts as 1); write delay_scale only while idle. One item is accepted every clock
// cycle while in_stall is low; each item is held in the input register, then the
// sequencer step writes its result into the result queue, from whose head it is
// offered. The two-entry result queue absorbs results while out_stall holds its
// head; in_stall rises when both entries are held and the input register holds an
// item.

module i2c_master_bit_sequencer_core import i2cms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic [7:0] delay_scale_q;
	logic       s1_valid_q;
	in_item_t   item_s1;
	out_item_t  result;
	out_item_t  slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       room, push, pop, in_acc;

	assign room      = (cnt_q != 2'd2);
	assign push      = s1_valid_q && room;
	assign pop       = out_valid && !out_stall;
	assign in_stall  = s1_valid_q && !room;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot0_q;

	// Delay scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_scale_q <= DELAY_SCALE_RST;
		end else if (cfg_wr_en) begin
			delay_scale_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_data;
		end
	end

	i2cms_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (push),
		.item        (item_s1),
		.delay_scale (delay_scale_q),
		.result      (result)
	);

	// Result queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Result queue entries; head is slot0
	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					slot0_q <= result;
				end else begin
					slot1_q <= result;
				end
			end
			2'b01: slot0_q <= slot1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					slot0_q <= result;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= result;
				end
			end
			default: slot0_q <= slot0_q;
		endcase
	end

endmodule

@@ hdl/i2cms_chk.sv @@
// Port-level checker for the I2C master bit sequencer, bound to the top level.
`timescale 1ns / 1ps

module i2cms_chk import i2cms_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input out_item_t  out_data
);

	// A stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// A stalled result item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result item changed while stalled");

	// Input backpressure only when results are backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// A finished command leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done with busy still set");

	// A rejected command only happens while busy and never finishes anything
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rejected |-> out_data.busy_res && !out_data.done_res)
		else $error("rejected item while idle or done");

endmodule

bind i2c_master_bit_sequencer_core i2cms_chk u_i2cms_chk (.*);
